// ===== sv/aked_pkg.sv =====
package aked_pkg;

  typedef enum logic [3:0] {
    KEY_CHAR   = 4'd0,
    KEY_UP     = 4'd1,
    KEY_DOWN   = 4'd2,
    KEY_RIGHT  = 4'd3,
    KEY_LEFT   = 4'd4,
    KEY_PGUP   = 4'd5,
    KEY_PGDN   = 4'd6,
    KEY_INS    = 4'd7,
    KEY_DEL    = 4'd8,
    KEY_HOME   = 4'd9,
    KEY_END    = 4'd10,
    KEY_BS     = 4'd11,
    KEY_ENTER  = 4'd12,
    KEY_CANCEL = 4'd13
  } key_kind_t;

  typedef enum logic [2:0] {
    PM_NORMAL = 3'd0,
    PM_ESC    = 3'd1,
    PM_NUM    = 3'd2,
    PM_MOD    = 3'd3,
    PM_O      = 3'd4
  } parse_mode_t;

  typedef struct packed {
    logic       emit;
    key_kind_t  kind;
    logic       ctrl_mod;
    logic [7:0] char_code;
  } key_event_t;

  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ETX    = 8'h03;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] NUM_MAX   = 8'd255;

  // key for ESC [ n ~, only meaningful for n = 1..6
  function automatic key_kind_t tilde_key(input logic [7:0] n);
    key_kind_t k;
    unique case (n)
      8'd1:    k = KEY_HOME;
      8'd2:    k = KEY_INS;
      8'd3:    k = KEY_DEL;
      8'd4:    k = KEY_END;
      8'd5:    k = KEY_PGUP;
      8'd6:    k = KEY_PGDN;
      default: k = KEY_CHAR;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/ansi_key_escape_decoder.sv =====
// Terminal key decoder: takes one received byte per transfer and gives one key event
// per completed key (plain character, backspace, enter, cancel, cursor and editing keys
// from ESC [ ... and ESC O ... sequences); unknown sequences make no event. A byte is
// accepted every clock cycle when the output is not stalled, and a key event passes
// from its closing byte through the input register, then the parser state and decode
// logic feed the result register in a single step. Output backpressure passes
// combinationally to s_axis_tready through the input register.
module ansi_key_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] char_code
  output logic [4:0] m_axis_tuser    // [3:0] key_kind, [4] ctrl_mod
);
  import aked_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_ready;
  logic       step;
  key_event_t evt;

  assign step = in_valid && out_ready;

  aked_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_byte   (s_axis_tdata),
    .take     (step),
    .in_valid (in_valid),
    .in_byte  (in_byte)
  );

  aked_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_byte),
    .evt     (evt)
  );

  aked_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (in_valid),
    .evt        (evt),
    .ready      (out_ready),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .m_data     (m_axis_tdata),
    .m_user     (m_axis_tuser)
  );

`ifndef ASSERT_OFF
  // only character events carry a byte
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[3:0] != KEY_CHAR) |-> (m_axis_tdata == 8'd0))
    else $error("non-character key carries a byte");

  // the modifier only comes with cursor and tilde keys
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[4] |->
      (m_axis_tuser[3:0] != KEY_CHAR) && (m_axis_tuser[3:0] != KEY_BS) &&
      (m_axis_tuser[3:0] != KEY_ENTER) && (m_axis_tuser[3:0] != KEY_CANCEL))
    else $error("modifier on a key that cannot have one");

  // a consumed item that makes an event always shows up at the output
  assert property (@(posedge clk) disable iff (rst)
    step && evt.emit |=> m_axis_tvalid)
    else $error("key event lost");
`endif

endmodule

// ===== sv/aked_in_stage.sv =====
module aked_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_valid,
  output logic       s_ready,
  input  logic [7:0] s_byte,
  input  logic       take,
  output logic       in_valid,
  output logic [7:0] in_byte
);

  assign s_ready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_ready) begin
      in_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      in_byte <= s_byte;
    end
  end

endmodule

// ===== sv/aked_parser.sv =====
module aked_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          in_byte,
  output aked_pkg::key_event_t evt
);
  import aked_pkg::*;

  parse_mode_t mode, mode_next;
  logic [7:0]  seq_number, seq_number_next;
  logic        mod_flag, mod_flag_next;

  logic        is_digit;
  logic [11:0] num_acc;

  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  // seq_number * 10 + digit, saturated below
  assign num_acc = {4'd0, seq_number} * 12'd10 + {8'd0, in_byte[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= PM_NORMAL;
      seq_number <= 8'd0;
      mod_flag   <= 1'b0;
    end else if (step) begin
      mode       <= mode_next;
      seq_number <= seq_number_next;
      mod_flag   <= mod_flag_next;
    end
  end

  always_comb begin
    mode_next       = PM_NORMAL;
    seq_number_next = seq_number;
    mod_flag_next   = mod_flag;
    evt             = '0;
    evt.kind        = KEY_CHAR;
    unique case (mode)
      PM_ESC: begin
        if (in_byte == CH_LBRACK) begin
          mode_next       = PM_NUM;
          seq_number_next = 8'd0;
          mod_flag_next   = 1'b0;
        end else if (in_byte == CH_O) begin
          mode_next = PM_O;
        end
      end
      PM_NUM, PM_MOD: begin
        if (is_digit) begin
          mode_next = mode;
          if (mode == PM_NUM) begin
            seq_number_next = (num_acc > {4'd0, NUM_MAX}) ? NUM_MAX : num_acc[7:0];
          end
        end else if (in_byte == CH_SEMI) begin
          mode_next     = PM_MOD;
          mod_flag_next = 1'b1;
        end else begin
          evt.ctrl_mod = mod_flag;
          unique case (in_byte)
            CH_A: begin
              evt.emit = 1'b1;
              evt.kind = KEY_UP;
            end
            CH_B: begin
              evt.emit = 1'b1;
              evt.kind = KEY_DOWN;
            end
            CH_C: begin
              evt.emit = 1'b1;
              evt.kind = KEY_RIGHT;
            end
            CH_D: begin
              evt.emit = 1'b1;
              evt.kind = KEY_LEFT;
            end
            CH_TILDE: begin
              evt.emit = (seq_number >= 8'd1) && (seq_number <= 8'd6);
              evt.kind = tilde_key(seq_number);
            end
            default: evt.emit = 1'b0;
          endcase
        end
      end
      PM_O: begin
        if (in_byte == CH_F) begin
          evt.emit = 1'b1;
          evt.kind = KEY_END;
        end else if (in_byte == CH_H) begin
          evt.emit = 1'b1;
          evt.kind = KEY_HOME;
        end
      end
      default: begin
        evt.emit = 1'b1;
        unique case (in_byte)
          CH_ESC: begin
            mode_next = PM_ESC;
            evt.emit  = 1'b0;
          end
          CH_BS, CH_DEL: evt.kind = KEY_BS;
          CH_CR:         evt.kind = KEY_ENTER;
          CH_ETX:        evt.kind = KEY_CANCEL;
          default:       evt.char_code = in_byte;
        endcase
      end
    endcase
  end

endmodule

// ===== sv/aked_out_stage.sv =====
module aked_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load_valid,
  input  aked_pkg::key_event_t evt,
  output logic                 ready,
  output logic                 m_valid,
  input  logic                 m_ready,
  output logic [7:0]           m_data,
  output logic [4:0]           m_user
);
  import aked_pkg::*;

  logic load;

  assign ready = !m_valid || m_ready;
  // items that make no key event are consumed without a transfer
  assign load  = ready && load_valid && evt.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (ready) begin
      m_valid <= load_valid && evt.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_data <= evt.char_code;
      m_user <= {evt.ctrl_mod, evt.kind};
    end
  end

endmodule

// ===== verif/ansi_key_escape_decoder_tb.sv =====
module ansi_key_escape_decoder_tb;
  import aked_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int RANDOM_BYTES   = 1900;

  class key_scoreboard;
    parse_mode_t mode;
    logic [7:0]  key_num;
    logic        mod_seen;
    key_event_t  expected_q[$];
    int          errors;

    function new();
      mode     = PM_NORMAL;
      key_num  = '0;
      mod_seen = 1'b0;
      errors   = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // advance the parser copy by one received byte
    function void note_byte(input logic [7:0] c);
      key_event_t  ev;
      int unsigned v;
      ev = '0;
      case (mode)
        PM_ESC: begin
          if (c == CH_LBRACK) begin
            mode     = PM_NUM;
            key_num  = '0;
            mod_seen = 1'b0;
          end else if (c == CH_O) begin
            mode = PM_O;
          end else begin
            mode = PM_NORMAL;
          end
        end
        PM_NUM, PM_MOD: begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            // modifier digits are not stored
            if (mode == PM_NUM) begin
              v = 32'(key_num) * 10 + 32'(c - CH_ZERO);
              key_num = (v > 32'(NUM_MAX)) ? NUM_MAX : v[7:0];
            end
          end else if (c == CH_SEMI) begin
            mode     = PM_MOD;
            mod_seen = 1'b1;
          end else begin
            mode        = PM_NORMAL;
            ev.ctrl_mod = mod_seen;
            ev.emit     = 1'b1;
            case (c)
              CH_A: ev.kind = KEY_UP;
              CH_B: ev.kind = KEY_DOWN;
              CH_C: ev.kind = KEY_RIGHT;
              CH_D: ev.kind = KEY_LEFT;
              CH_TILDE: begin
                case (key_num)
                  8'd1:    ev.kind = KEY_HOME;
                  8'd2:    ev.kind = KEY_INS;
                  8'd3:    ev.kind = KEY_DEL;
                  8'd4:    ev.kind = KEY_END;
                  8'd5:    ev.kind = KEY_PGUP;
                  8'd6:    ev.kind = KEY_PGDN;
                  default: ev.emit = 1'b0;
                endcase
              end
              default: ev.emit = 1'b0;
            endcase
          end
        end
        PM_O: begin
          mode = PM_NORMAL;
          if (c == CH_F) begin
            ev.emit = 1'b1;
            ev.kind = KEY_END;
          end else if (c == CH_H) begin
            ev.emit = 1'b1;
            ev.kind = KEY_HOME;
          end
        end
        default: begin
          mode    = PM_NORMAL;
          ev.emit = 1'b1;
          case (c)
            CH_ESC: begin
              mode    = PM_ESC;
              ev.emit = 1'b0;
            end
            CH_BS, CH_DEL: ev.kind = KEY_BS;
            CH_CR:         ev.kind = KEY_ENTER;
            CH_ETX:        ev.kind = KEY_CANCEL;
            default: begin
              ev.kind      = KEY_CHAR;
              ev.char_code = c;
            end
          endcase
        end
      endcase
      if (ev.emit)
        expected_q.push_back(ev);
    endfunction

    function void check_event(input logic [7:0] code, input logic [4:0] user);
      key_event_t exp_ev;
      if (expected_q.size() == 0) begin
        $error("unexpected key event: key_kind %0d ctrl_mod %0d char_code 0x%02h",
               user[3:0], user[4], code);
        errors++;
        return;
      end
      exp_ev = expected_q.pop_front();
      if (user[3:0] !== exp_ev.kind) begin
        $error("key_kind: expected %0d, actual %0d", exp_ev.kind, user[3:0]);
        errors++;
      end
      if (user[4] !== exp_ev.ctrl_mod) begin
        $error("ctrl_mod: expected %0d, actual %0d", exp_ev.ctrl_mod, user[4]);
        errors++;
      end
      if (code !== exp_ev.char_code) begin
        $error("char_code: expected 0x%02h, actual 0x%02h", exp_ev.char_code, code);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [7:0] rx_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [7:0] char_code
  logic [4:0] m_axis_tuser;        // [3:0] key_kind, [4] ctrl_mod

  key_scoreboard sb = new();
  logic          steady_run = 1'b0;
  int            bytes_sent = 0;
  int            idle_cycles;
  logic [7:0]    seq_bytes[$];

  ansi_key_escape_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait();
    return steady_run ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_seq();
    foreach (seq_bytes[i])
      send_byte(seq_bytes[i]);
  endtask

  // appends the decimal digits of n
  task automatic push_number(input int unsigned n);
    int unsigned div;
    div = 1;
    while (div * 10 <= n)
      div *= 10;
    while (div > 0) begin
      seq_bytes.push_back(CH_ZERO + 8'((n / div) % 10));
      div /= 10;
    end
  endtask

  // no transfer on either side for too long means the block hung
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_event(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    int pick;
    int num_kind;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, control keys, modifier, ESC O, overflowed number, doubled ESC
    seq_bytes = '{8'h00, 8'hFF, CH_BS, CH_DEL, CH_CR, CH_ETX,
                  CH_ESC, CH_LBRACK, CH_ZERO + 8'd3, CH_SEMI, CH_ZERO + 8'd5, CH_TILDE,
                  CH_ESC, CH_O, CH_H,
                  CH_ESC, CH_LBRACK, CH_NINE, CH_NINE, CH_NINE, CH_TILDE,
                  CH_ESC, CH_ESC, 8'h78};
    send_seq();

    while (bytes_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 59) == 0)
        steady_run = ~steady_run;
      seq_bytes = {};
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        seq_bytes.push_back(CH_ESC);
        seq_bytes.push_back(CH_LBRACK);
        num_kind = $urandom_range(0, 5);
        if (num_kind >= 1 && num_kind <= 3)
          push_number($urandom_range(0, 9));
        else if (num_kind == 4)
          push_number($urandom_range(0, 300));
        else if (num_kind == 5)
          repeat ($urandom_range(3, 5))
            seq_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) begin
          seq_bytes.push_back(CH_SEMI);
          repeat ($urandom_range(0, 2))
            seq_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 3) == 0)
            seq_bytes.push_back(CH_SEMI);
        end
        case ($urandom_range(0, 8))
          0: seq_bytes.push_back(CH_A);
          1: seq_bytes.push_back(CH_B);
          2: seq_bytes.push_back(CH_C);
          3: seq_bytes.push_back(CH_D);
          4, 5, 6: seq_bytes.push_back(CH_TILDE);
          7: seq_bytes.push_back(8'($urandom_range(0, 255)));
          default: ;  // cut short, the next bytes close it
        endcase
      end else if (pick < 50) begin
        seq_bytes.push_back(CH_ESC);
        seq_bytes.push_back(CH_O);
        case ($urandom_range(0, 2))
          0: seq_bytes.push_back(CH_F);
          1: seq_bytes.push_back(CH_H);
          default: seq_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end else if (pick < 58) begin
        seq_bytes.push_back(CH_ESC);
        seq_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 65) begin
        case ($urandom_range(0, 3))
          0: seq_bytes.push_back(CH_BS);
          1: seq_bytes.push_back(CH_DEL);
          2: seq_bytes.push_back(CH_CR);
          default: seq_bytes.push_back(CH_ETX);
        endcase
      end else begin
        seq_bytes.push_back(8'($urandom_range(0, 255)));
      end
      send_seq();
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/aked_pkg.sv
sv/aked_in_stage.sv
sv/aked_parser.sv
sv/aked_out_stage.sv
sv/ansi_key_escape_decoder.sv
verif/ansi_key_escape_decoder_tb.sv
